>>> sv/b64d_pkg.sv
package b64d_pkg;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_LEN  = 2'd1;
  localparam logic [1:0] ST_BAD_CHAR = 2'd2;

  // Padding character and sextet width.
  localparam logic [7:0] PAD_CHAR = 8'h3D;
  localparam int unsigned SEXTET_W = 6;

  // One decoded group: up to three bytes bound for the output port.
  typedef struct packed {
    logic [23:0] word;    // bytes, first byte in the top bits
    logic [1:0]  count;   // number of bytes to send, 1 to 3
    logic        last;    // group closes the message
    logic [1:0]  status;  // status code carried by every byte of the group
  } group_t;

  // Status of the output stage seen by the decoder.
  typedef struct packed {
    logic can_push;  // queue has room for one more group
    logic empty;     // nothing queued and nothing in flight
  } q_stat_t;

endpackage

>>> sv/b64d_char_if.sv
interface b64d_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_message;

  modport source (output valid, output char_in, output end_of_message, input ready);
  modport sink   (input valid, input char_in, input end_of_message, output ready);
endinterface

>>> sv/b64d_byte_if.sv
interface b64d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_of_message;
  logic [1:0] status;

  modport source (output valid, output data_byte, output last_of_message, output status,
                  input ready);
  modport sink   (input valid, input data_byte, input last_of_message, input status,
                  output ready);
endinterface

>>> sv/base64_stream_decoder_unit.sv
// Streaming Base64 decoder. One character beat is accepted per clock whenever
// the two-entry group queue has room; each character is decoded in the cycle it
// is taken, and every complete group of four characters (or the final group of
// a message) is queued as up to three byte beats, offered in the next cycle at
// the earliest. While the consumer is ready, the output port sends one byte per
// cycle, so a steady stream of full groups runs at one character per cycle.
// The input stalls whenever both queue entries are occupied, which happens when
// the consumer throttles or when a short message closes while a full group is
// still being sent. A message that ends with a bad length or a bad character
// closes with a single beat carrying status and a zero byte, and its earlier
// bytes are to be dropped by the consumer. cfg_wdata_i selects the URL
// alphabet; write it only while the decoder is idle.
module base64_stream_decoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  b64d_char_if.sink   in_if,
  b64d_byte_if.source out_if
);
  import b64d_pkg::*;

  // Character to sextet lookup; bit 6 set means not in the alphabet.
  function automatic logic [6:0] sextet_of(input logic [7:0] c, input logic url);
    logic [6:0] r;
    r = 7'h40;
    if (c >= 8'h41 && c <= 8'h5A)      r = {1'b0, 6'(c - 8'h41)};
    else if (c >= 8'h61 && c <= 8'h7A) r = {1'b0, 6'(c - 8'h61 + 8'd26)};
    else if (c >= 8'h30 && c <= 8'h39) r = {1'b0, 6'(c - 8'h30 + 8'd52)};
    else if (url && c == 8'h2D)        r = 7'd62;
    else if (url && c == 8'h5F)        r = 7'd63;
    else if (!url && c == 8'h2B)       r = 7'd62;
    else if (!url && c == 8'h2F)       r = 7'd63;
    return r;
  endfunction

  logic        url_q;
  logic [17:0] accum_q, accum_d;
  logic [1:0]  pos_q, pos_d;
  logic        tpad_q, tpad_d;
  logic        bad_q, bad_d;

  logic        beat_in;
  logic [6:0]  lut;
  logic [5:0]  v;
  logic        pad;
  logic        bad;
  logic        bad_seen;
  logic        tpad_new;
  logic        eom;
  logic [17:0] accum_new;
  logic        push;
  group_t      grp;
  q_stat_t     qstat;

  assign in_if.ready = qstat.can_push;
  assign beat_in     = in_if.valid && in_if.ready;
  assign eom         = in_if.end_of_message;
  assign pad         = (in_if.char_in == PAD_CHAR);
  assign lut         = sextet_of(in_if.char_in, url_q);

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      url_q <= 1'b0;
    end else if (cfg_we_i) begin
      url_q <= cfg_wdata_i;
    end
  end

  // Per-position character check and padding rules.
  always_comb begin
    v        = lut[5:0];
    bad      = 1'b0;
    tpad_new = tpad_q;
    unique case (pos_q)
      2'd0, 2'd1: bad = lut[6];
      2'd2: begin
        if (pad) begin
          v        = '0;
          tpad_new = 1'b1;
        end else begin
          bad = lut[6];
        end
      end
      default: begin
        if (tpad_q) begin
          bad = !(pad && eom);
          v   = '0;
        end else if (pad) begin
          bad = !eom;
          v   = '0;
        end else begin
          bad = lut[6];
        end
      end
    endcase
    if (bad) begin
      v = '0;
    end
    bad_seen  = bad_q || bad;
    accum_new = (pos_q != 2'd3) ? {accum_q[11:0], v} : accum_q;
  end

  // Group assembly, result generation and state update.
  always_comb begin
    accum_d    = accum_new;
    pos_d      = pos_q + 2'd1;
    tpad_d     = tpad_new;
    bad_d      = bad_seen;
    push       = 1'b0;
    grp.word   = {accum_q, v};
    grp.count  = 2'd3;
    grp.last   = 1'b0;
    grp.status = ST_OK;
    if (!eom) begin
      if (pos_q == 2'd3) begin
        push    = !bad_seen;
        accum_d = '0;
        pos_d   = 2'd0;
        tpad_d  = 1'b0;
      end
    end else begin
      push     = 1'b1;
      grp.last = 1'b1;
      priority if (pos_q == 2'd0 || (!url_q && pos_q != 2'd3)) begin
        grp.word   = '0;
        grp.count  = 2'd1;
        grp.status = ST_BAD_LEN;
      end else if (bad_seen) begin
        grp.word   = '0;
        grp.count  = 2'd1;
        grp.status = ST_BAD_CHAR;
      end else if (pos_q == 2'd1) begin
        grp.word  = {accum_new[11:0], 12'd0};
        grp.count = 2'd1;
      end else if (pos_q == 2'd2) begin
        grp.word  = {accum_new, 6'd0};
        grp.count = pad ? 2'd1 : 2'd2;
      end else begin
        grp.word  = {accum_q, v};
        grp.count = tpad_q ? 2'd1 : (pad ? 2'd2 : 2'd3);
      end
      accum_d = '0;
      pos_d   = 2'd0;
      tpad_d  = 1'b0;
      bad_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_q <= '0;
      pos_q   <= 2'd0;
      tpad_q  <= 1'b0;
      bad_q   <= 1'b0;
    end else if (beat_in) begin
      accum_q <= accum_d;
      pos_q   <= pos_d;
      tpad_q  <= tpad_d;
      bad_q   <= bad_d;
    end
  end

  // Group queue and byte serializer.
  b64d_out_stage u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (beat_in && push),
    .grp_i  (grp),
    .stat_o (qstat),
    .out_if (out_if)
  );

`ifndef SYNTHESIS
  // A message end always leaves a clean group state behind.
  a_eom_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat_in && eom |=> pos_q == 2'd0 && !bad_q && !tpad_q)
    else $error("group state not cleared after message end");

  // Error beats always close the message.
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.status != ST_OK |-> out_if.last_of_message)
    else $error("error beat without last_of_message");

  // Error beats carry a zero byte.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.status != ST_OK |-> out_if.data_byte == 8'd0)
    else $error("error beat with nonzero data");

  // An empty queue offers nothing on the output.
  a_empty_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qstat.empty |-> !out_if.valid)
    else $error("output valid while queue empty");
`endif

endmodule

>>> sv/b64d_out_stage.sv
module b64d_out_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  b64d_pkg::group_t grp_i,
  output b64d_pkg::q_stat_t stat_o,
  b64d_byte_if.source     out_if
);
  import b64d_pkg::*;

  // Two-entry group queue.
  group_t     entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic [1:0] idx_q, idx_d;

  group_t head;
  logic   beat_out;
  logic   pop;
  logic   do_push;

  assign head     = entry_q[rd_ptr_q];
  assign beat_out = out_if.valid && out_if.ready;
  assign pop      = beat_out && (idx_q == head.count - 2'd1);
  assign do_push  = push_i && (fill_q != 2'd2);

  // Byte selection from the head group.
  always_comb begin
    out_if.valid           = (fill_q != 2'd0);
    out_if.last_of_message = head.last && (idx_q == head.count - 2'd1);
    out_if.status          = head.status;
    unique case (idx_q)
      2'd0:    out_if.data_byte = head.word[23:16];
      2'd1:    out_if.data_byte = head.word[15:8];
      default: out_if.data_byte = head.word[7:0];
    endcase
  end

  assign stat_o.can_push = (fill_q != 2'd2);
  assign stat_o.empty    = (fill_q == 2'd0);

  // Pointer, fill and byte index update.
  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + {1'b0, do_push} - {1'b0, pop};
    if (pop) begin
      idx_d = 2'd0;
    end else if (beat_out) begin
      idx_d = idx_q + 2'd1;
    end else begin
      idx_d = idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
      idx_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
      idx_q    <= idx_d;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= grp_i;
    end
  end

endmodule

>>> verif/b64d_stream_checker.sv
module b64d_stream_checker (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  b64d_char_if char_bus,
  b64d_byte_if byte_bus,
  output int   fail_count,
  output int   expected_left,
  output int   beats_checked,
  output int   len_err_beats,
  output int   char_err_beats
);
  import b64d_pkg::*;

  localparam logic [6:0] NO_SEXTET = 7'd64;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [1:0] status;
  } byte_beat_t;

  // Byte beats still owed by the decoder, oldest first.
  byte_beat_t expected_bytes[$];

  // Shadow of the decoder state and its alphabet register.
  logic [17:0] sextet_acc;
  logic [1:0]  group_pos;
  logic        pad_third;
  logic        bad_char;
  logic        url_mode;

  // Maps a character to its sextet, or to NO_SEXTET when it is outside the alphabet.
  function automatic logic [6:0] sextet_value(input logic [7:0] c, input logic url);
    if (c >= 8'h41 && c <= 8'h5A) return 7'(c - 8'h41);
    if (c >= 8'h61 && c <= 8'h7A) return 7'(c - 8'h61 + 8'd26);
    if (c >= 8'h30 && c <= 8'h39) return 7'(c - 8'h30 + 8'd52);
    if (c == (url ? CH_DASH : CH_PLUS)) return 7'd62;
    if (c == (url ? CH_UNDER : CH_SLASH)) return 7'd63;
    return NO_SEXTET;
  endfunction

  task automatic expect_beat(input logic [7:0] data, input logic last, input logic [1:0] status);
    byte_beat_t b;
    b.data   = data;
    b.last   = last;
    b.status = status;
    expected_bytes.push_back(b);
  endtask

  // Advances the shadow state by one character and queues the byte beats it releases.
  task automatic decode_char(input logic [7:0] c, input logic eom);
    logic [6:0]  v;
    logic [1:0]  pos;
    logic [23:0] word;
    logic        pad;
    logic        bad;
    int          count;
    pos   = group_pos;
    v     = sextet_value(c, url_mode);
    pad   = (c == PAD_CHAR);
    bad   = 1'b0;
    count = 0;

    // Padding is legal only in the third and fourth place of the last group.
    if (pos < 2'd2) begin
      bad = v[6];
    end else if (pos == 2'd2) begin
      if (pad) begin
        v         = '0;
        pad_third = 1'b1;
      end else begin
        bad = v[6];
      end
    end else if (pad_third) begin
      bad = !(pad && eom);
      v   = '0;
    end else if (pad) begin
      bad = !eom;
      v   = '0;
    end else begin
      bad = v[6];
    end
    if (bad) begin
      bad_char = 1'b1;
      v        = '0;
    end

    if (pos != 2'd3) sextet_acc = {sextet_acc[11:0], v[5:0]};
    word = {sextet_acc, v[5:0]};

    // Message end: length error wins over a character error.
    if (eom && (pos == 2'd0 || (!url_mode && pos != 2'd3))) begin
      expect_beat(8'h00, 1'b1, ST_BAD_LEN);
    end else if (eom && bad_char) begin
      expect_beat(8'h00, 1'b1, ST_BAD_CHAR);
    end else if (eom) begin
      case (pos)
        2'd1: begin
          word  = {sextet_acc[11:0], 12'h000};
          count = 1;
        end
        2'd2: begin
          word  = {sextet_acc, 6'h00};
          count = pad ? 1 : 2;
        end
        default: begin
          count = pad_third ? 1 : (pad ? 2 : 3);
        end
      endcase
    end else if (pos == 2'd3 && !bad_char) begin
      count = 3;
    end

    for (int i = 0; i < count; i++) begin
      expect_beat(word[23 - 8 * i -: 8], eom && (i == count - 1), ST_OK);
    end

    if (eom || pos == 2'd3) begin
      sextet_acc = '0;
      group_pos  = '0;
      pad_third  = 1'b0;
    end else begin
      group_pos = pos + 2'd1;
    end
    if (eom) bad_char = 1'b0;
  endtask

  // Sample both channels at the rising edge; output beats at an edge stem from earlier input.
  always @(posedge clk_i or negedge rst_ni) begin
    byte_beat_t seen;
    byte_beat_t want;
    if (!rst_ni) begin
      expected_bytes.delete();
      sextet_acc     = '0;
      group_pos      = '0;
      pad_third      = 1'b0;
      bad_char       = 1'b0;
      url_mode       = 1'b0;
      fail_count     = 0;
      expected_left  = 0;
      beats_checked  = 0;
      len_err_beats  = 0;
      char_err_beats = 0;
    end else begin
      if (byte_bus.valid && byte_bus.ready) begin
        seen.data   = byte_bus.data_byte;
        seen.last   = byte_bus.last_of_message;
        seen.status = byte_bus.status;
        beats_checked++;
        if (seen.status == ST_BAD_LEN) len_err_beats++;
        if (seen.status == ST_BAD_CHAR) char_err_beats++;
        if (expected_bytes.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected beat: expected none, got byte %02h last %0b status %0d",
                   $time, seen.data, seen.last, seen.status);
        end else begin
          want = expected_bytes.pop_front();
          if (seen.data !== want.data || seen.last !== want.last ||
              seen.status !== want.status) begin
            fail_count++;
            $display("%0t: mismatch: expected %02h/%0b/%0d got %02h/%0b/%0d (byte/last/status)",
                     $time, want.data, want.last, want.status,
                     seen.data, seen.last, seen.status);
          end
        end
      end
      if (char_bus.valid && char_bus.ready) begin
        decode_char(char_bus.char_in, char_bus.end_of_message);
      end
      if (cfg_we_i) url_mode = cfg_wdata_i;
      expected_left = expected_bytes.size();
    end
  end

endmodule

>>> verif/tb_top.sv
module tb_top;
  import b64d_pkg::*;

  localparam int CLK_PERIOD      = 12;
  localparam int RESET_CYCLES    = 8;
  localparam int SETTLE_CYCLES   = 8;
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int ITEMS_PER_PHASE = 76;
  localparam int RUN_LIMIT       = 3_000_000;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  int fail_count;
  int expected_left;
  int beats_checked;
  int len_err_beats;
  int char_err_beats;

  b64d_char_if char_bus ();
  b64d_byte_if byte_bus ();

  logic [7:0] msg_chars[$];
  bit         send_idle;
  bit         hold_request;
  int         chars_sent;
  int         msgs_sent;
  int         cfg_writes;

  base64_stream_decoder_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (char_bus),
    .out_if      (byte_bus)
  );

  b64d_stream_checker chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .char_bus       (char_bus),
    .byte_bus       (byte_bus),
    .fail_count     (fail_count),
    .expected_left  (expected_left),
    .beats_checked  (beats_checked),
    .len_err_beats  (len_err_beats),
    .char_err_beats (char_err_beats)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  initial begin
    #(RUN_LIMIT);
    $display("%0t: timeout with %0d byte beats outstanding", $time, expected_left);
    $display("** base64_stream_decoder_unit: FAILED **");
    $finish;
  end

  // Encodes one sextet in the selected alphabet.
  function automatic logic [7:0] b64_symbol(input logic [5:0] s, input logic url);
    if (s < 6'd26) return 8'h41 + 8'(s);
    if (s < 6'd52) return 8'h61 + 8'(s) - 8'd26;
    if (s < 6'd62) return 8'h30 + 8'(s) - 8'd52;
    if (s == 6'd62) return url ? CH_DASH : CH_PLUS;
    return url ? CH_UNDER : CH_SLASH;
  endfunction

  // Offers one character beat after an optional gap and returns at the falling edge
  // after it was taken. The caller either offers the next beat or drops valid there.
  task automatic send_char(input logic [7:0] c, input logic eom);
    int gap;
    gap = send_idle ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      char_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    char_bus.valid          <= 1'b1;
    char_bus.char_in        <= c;
    char_bus.end_of_message <= eom;
    do @(posedge clk_i); while (char_bus.ready !== 1'b1);
    chars_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], i == s.len() - 1);
    end
    msgs_sent++;
  endtask

  // Waits until every owed beat has arrived, then lets the pipeline go quiet.
  task automatic drain_and_settle();
    char_bus.valid <= 1'b0;
    while (expected_left != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_alphabet(input logic url);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= url;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_writes++;
  endtask

  // Byte consumer: random stalls per beat, runs of no stalls, and one long hold-off.
  initial begin
    int gap;
    bit recv_idle;
    bit hold_taken;
    byte_bus.ready = 1'b0;
    recv_idle      = 1'b0;
    hold_taken     = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 15) == 0) recv_idle = !recv_idle;
      gap = recv_idle ? $urandom_range(0, 19) : 0;
      if (hold_request && !hold_taken) begin
        hold_taken = 1'b1;
        gap        = HOLD_OFF_CYCLES;
      end
      if (gap > 0) begin
        byte_bus.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      byte_bus.ready <= 1'b1;
      do @(posedge clk_i); while (byte_bus.valid !== 1'b1);
      @(negedge clk_i);
    end
  end

  // Character producer and verdict.
  initial begin
    int         phase_items;
    int         burst;
    int         kind;
    int         len;
    int         nbytes;
    int         idx;
    bit         hold_done;
    logic       url_mode;
    logic [23:0] word;

    rst_ni                  = 1'b0;
    cfg_we_i                = 1'b0;
    cfg_wdata_i             = 1'b0;
    char_bus.valid          = 1'b0;
    char_bus.char_in        = 8'h00;
    char_bus.end_of_message = 1'b0;
    hold_request            = 1'b0;
    hold_done               = 1'b0;
    burst                   = 0;
    chars_sent              = 0;
    msgs_sent               = 0;
    cfg_writes              = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Standard alphabet out of reset: padded endings, all-ones bytes, early padding,
    // and a lone bad character where the length error must win.
    send_idle = $urandom_range(0, 1);
    send_text("TQ==");
    send_text("//8=");
    send_text("=AAA");
    send_char(8'hFF, 1'b1);
    msgs_sent++;
    drain_and_settle();

    // URL alphabet: unpadded endings of two and three characters, a short padded
    // ending, and a third-place pad followed by a fourth character that is no pad.
    write_alphabet(1'b1);
    send_text("-_");
    send_text("TWE");
    send_text("TQ=");
    send_text("AB=C");
    drain_and_settle();

    // Random phases, alternating the alphabet.
    for (int ph = 0; ph < 4; ph++) begin
      url_mode = (ph % 2 == 1);
      write_alphabet(url_mode);
      phase_items = 0;
      while (phase_items < ITEMS_PER_PHASE) begin
        // Once, stop the consumer and keep feeding back to back so the input backs up.
        if (ph == 2 && !hold_done && phase_items >= 25) begin
          hold_request = 1'b1;
          hold_done    = 1'b1;
          burst        = 30;
        end

        kind = $urandom_range(0, 19);
        msg_chars.delete();
        if (kind >= 17) begin
          // Noise: random bytes mixed with pads and legal symbols.
          len = $urandom_range(1, 10);
          repeat (len) begin
            case ($urandom_range(0, 2))
              0: msg_chars.push_back(8'($urandom_range(0, 255)));
              1: msg_chars.push_back(PAD_CHAR);
              default: msg_chars.push_back(b64_symbol(6'($urandom_range(0, 63)), url_mode));
            endcase
          end
        end else begin
          nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 9);
          for (int g = 0; g < nbytes / 3; g++) begin
            word = 24'($urandom());
            for (int k = 3; k >= 0; k--) begin
              msg_chars.push_back(b64_symbol(word[6 * k +: 6], url_mode));
            end
          end
          if (nbytes % 3 != 0) begin
            // Bits past the last byte are random; the decoder has to ignore them.
            word = 24'($urandom());
            msg_chars.push_back(b64_symbol(word[23:18], url_mode));
            msg_chars.push_back(b64_symbol(word[17:12], url_mode));
            if (nbytes % 3 == 2) msg_chars.push_back(b64_symbol(word[11:6], url_mode));
            if (!url_mode || $urandom_range(0, 1) == 1) begin
              while (msg_chars.size() % 4 != 0) msg_chars.push_back(PAD_CHAR);
            end else if (nbytes % 3 == 1 && $urandom_range(0, 2) == 0) begin
              msg_chars.push_back(PAD_CHAR);
            end
          end

          // Corrupt a share of the well-formed messages.
          if (kind >= 14) begin
            idx = $urandom_range(0, msg_chars.size() - 1);
            case ($urandom_range(0, 4))
              0: msg_chars[idx] = 8'($urandom_range(0, 255));
              1: msg_chars[idx] = PAD_CHAR;
              2: begin
                if (url_mode) msg_chars[idx] = $urandom_range(0, 1) ? CH_PLUS : CH_SLASH;
                else msg_chars[idx] = $urandom_range(0, 1) ? CH_DASH : CH_UNDER;
              end
              3: begin
                if (msg_chars.size() > 1) void'(msg_chars.pop_back());
                else msg_chars.push_back(PAD_CHAR);
              end
              default: msg_chars.push_back(b64_symbol(6'($urandom_range(0, 63)), url_mode));
            endcase
          end
        end

        send_idle = (burst > 0) ? 1'b0 : ($urandom_range(0, 2) != 0);
        for (int i = 0; i < msg_chars.size(); i++) begin
          send_char(msg_chars[i], i == msg_chars.size() - 1);
        end
        msgs_sent++;
        phase_items += msg_chars.size();
        burst = (burst > msg_chars.size()) ? burst - msg_chars.size() : 0;
      end
      drain_and_settle();
    end

    $display("Run sent %0d characters in %0d messages with %0d alphabet writes (both alphabets).",
             chars_sent, msgs_sent, cfg_writes);
    $display("Checked %0d byte beats: %0d length errors, %0d character errors.",
             beats_checked, len_err_beats, char_err_beats);
    if (fail_count == 0 && expected_left == 0) begin
      $display("** base64_stream_decoder_unit: PASSED **");
    end else begin
      $display("** base64_stream_decoder_unit: FAILED **");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/b64d_pkg.sv
sv/b64d_char_if.sv
sv/b64d_byte_if.sv
sv/b64d_out_stage.sv
sv/base64_stream_decoder_unit.sv
verif/b64d_stream_checker.sv
verif/tb_top.sv
